### src/actuator_open_sequencer_defines.svh
// Assertion macros for the actuator open sequencer checker
`ifndef ACTUATOR_OPEN_SEQUENCER_DEFINES_SVH
`define ACTUATOR_OPEN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define AOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aos check failed");

// Next-cycle implication, held off during reset
`define AOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aos check failed");

`endif

### src/aos_pkg.sv
// Types, constants and helpers for the actuator open sequencer
`default_nettype none
package aos_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NOP    = 2'd3
    } aos_op_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OPENED  = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_CANCEL  = 2'd3
    } aos_status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_POLL    = 3'd2,
        PH_REVERSE = 3'd3
    } aos_phase_t;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GIVE_UP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_WAIT = 3'd5;

    localparam logic [CFG_W-1:0] START_DELAY_RST   = 16'd20;
    localparam logic [CFG_W-1:0] POLL_INTERVAL_RST = 16'd10;
    localparam logic [CFG_W-1:0] WINDOW_LOW_RST    = 16'd500;
    localparam logic [CFG_W-1:0] WINDOW_HIGH_RST   = 16'd550;
    localparam logic [CFG_W-1:0] GIVE_UP_RST       = 16'd1200;
    localparam logic [CFG_W-1:0] REVERSE_WAIT_RST  = 16'd50;

    typedef struct packed {
        logic [CFG_W-1:0] start_delay;
        logic [CFG_W-1:0] poll_interval;
        logic [CFG_W-1:0] window_low;
        logic [CFG_W-1:0] window_high;
        logic [CFG_W-1:0] give_up;
        logic [CFG_W-1:0] reverse_wait;
    } aos_cfg_t;

    typedef struct packed {
        aos_phase_t       phase;
        logic [CFG_W-1:0] wait_count;
        logic             open_level;
        logic             close_level;
        logic             busy;
        logic             finished;
    } aos_ctrl_t;

    // a delay of zero behaves as a single tick
    function automatic logic [CFG_W-1:0] load_delay(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

### src/aos_ifs.sv
// Command, result and configuration channel interfaces
`default_nettype none
interface aos_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       open_sensed;
    modport source (output valid, op, open_sensed, input ready);
    modport sink   (input valid, op, open_sensed, output ready);
endinterface

interface aos_res_if;
    logic       valid;
    logic       ready;
    logic       open_drive;
    logic       close_drive;
    logic       busy_res;
    logic       port_open_flag;
    logic [1:0] status;
    modport source (output valid, open_drive, close_drive, busy_res, port_open_flag, status,
                    input ready);
    modport sink   (input valid, open_drive, close_drive, busy_res, port_open_flag, status,
                    output ready);
endinterface

interface aos_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aos_pkg::CFG_IDX_W-1:0]  index;
    logic [aos_pkg::CFG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/aos_step.sv
// Next-state and status logic for one command of the open sequence
`default_nettype none
module aos_step #(
    parameter int TIME_WIDTH = aos_pkg::TIME_WIDTH_DEF
) (
    input  aos_pkg::aos_op_t        op,
    input  logic                    open_sensed,
    input  aos_pkg::aos_cfg_t       cfg_cur,
    input  aos_pkg::aos_ctrl_t      ctrl_cur,
    input  logic [TIME_WIDTH-1:0]   elapsed_cur,
    output aos_pkg::aos_ctrl_t      ctrl_nxt,
    output logic [TIME_WIDTH-1:0]   elapsed_nxt,
    output aos_pkg::aos_status_t    status
);
    localparam int CMP_W = (TIME_WIDTH > aos_pkg::CFG_W) ? TIME_WIDTH : aos_pkg::CFG_W;

    logic [TIME_WIDTH-1:0] elapsed_inc;
    logic [CMP_W-1:0]      el_x;
    logic                  in_window;
    logic                  past_give_up;

    assign elapsed_inc  = (elapsed_cur == '1) ? elapsed_cur : elapsed_cur + TIME_WIDTH'(1);
    assign el_x         = CMP_W'(elapsed_inc);
    assign in_window    = (el_x > CMP_W'(cfg_cur.window_low)) &&
                          (el_x < CMP_W'(cfg_cur.window_high));
    assign past_give_up = el_x > CMP_W'(cfg_cur.give_up);

    always_comb
    begin
        ctrl_nxt    = ctrl_cur;
        elapsed_nxt = elapsed_cur;
        status      = aos_pkg::ST_NONE;
        case (op)
            aos_pkg::OP_START:
            begin
                ctrl_nxt.busy       = 1'b1;
                ctrl_nxt.phase      = aos_pkg::PH_START;
                ctrl_nxt.wait_count = aos_pkg::load_delay(cfg_cur.start_delay);
                elapsed_nxt         = '0;
            end
            aos_pkg::OP_CANCEL:
            begin
                if (ctrl_cur.busy)
                begin
                    ctrl_nxt.phase      = aos_pkg::PH_IDLE;
                    ctrl_nxt.busy       = 1'b0;
                    ctrl_nxt.finished   = 1'b1;
                    ctrl_nxt.wait_count = '0;
                    status              = aos_pkg::ST_CANCEL;
                end
            end
            aos_pkg::OP_TICK:
            begin
                if (ctrl_cur.phase != aos_pkg::PH_IDLE)
                begin
                    elapsed_nxt = elapsed_inc;
                    if (ctrl_cur.wait_count > aos_pkg::CFG_W'(1))
                    begin
                        ctrl_nxt.wait_count = ctrl_cur.wait_count - aos_pkg::CFG_W'(1);
                    end
                    else
                    begin
                        ctrl_nxt.wait_count = '0;
                        // drive open after the start delay or a reversal
                        if (ctrl_cur.phase == aos_pkg::PH_START ||
                            ctrl_cur.phase == aos_pkg::PH_REVERSE)
                        begin
                            ctrl_nxt.close_level = 1'b0;
                            ctrl_nxt.open_level  = 1'b1;
                        end
                        if (open_sensed || (!in_window && past_give_up))
                        begin
                            ctrl_nxt.phase    = aos_pkg::PH_IDLE;
                            ctrl_nxt.busy     = 1'b0;
                            ctrl_nxt.finished = 1'b1;
                            status = open_sensed ? aos_pkg::ST_OPENED : aos_pkg::ST_TIMEOUT;
                        end
                        else if (in_window)
                        begin
                            ctrl_nxt.open_level  = 1'b0;
                            ctrl_nxt.close_level = 1'b1;
                            ctrl_nxt.phase       = aos_pkg::PH_REVERSE;
                            ctrl_nxt.wait_count  = aos_pkg::load_delay(cfg_cur.reverse_wait);
                        end
                        else
                        begin
                            ctrl_nxt.phase      = aos_pkg::PH_POLL;
                            ctrl_nxt.wait_count = aos_pkg::load_delay(cfg_cur.poll_interval);
                        end
                    end
                end
            end
            default:
            begin
                // no operation: hold everything
            end
        endcase
    end
endmodule
`default_nettype wire

### src/actuator_open_sequencer.sv
// A result is offered in the cycle after its command transfer.
// Throughput: one command per cycle; the whole state update sits in one
// combinational step between the state registers and the result register.
// A waiting result stalls the next command unless the sink takes it.
// Reset clears the sequence state and loads the default register values.
`default_nettype none
module actuator_open_sequencer #(
    parameter int TIME_WIDTH = aos_pkg::TIME_WIDTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    aos_cmd_if.sink      cmd,
    aos_res_if.source    res,
    aos_cfg_if.sink      cfg
);
    aos_pkg::aos_cfg_t     cfg_reg;
    aos_pkg::aos_ctrl_t    ctrl_reg;
    aos_pkg::aos_ctrl_t    ctrl_next;
    logic [TIME_WIDTH-1:0] elapsed_reg;
    logic [TIME_WIDTH-1:0] elapsed_next;
    aos_pkg::aos_status_t  status_next;
    aos_pkg::aos_status_t  status_reg;
    logic                  res_valid_reg;
    logic                  cmd_xfer;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    aos_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .op          (aos_pkg::aos_op_t'(cmd.op)),
        .open_sensed (cmd.open_sensed),
        .cfg_cur     (cfg_reg),
        .ctrl_cur    (ctrl_reg),
        .elapsed_cur (elapsed_reg),
        .ctrl_nxt    (ctrl_next),
        .elapsed_nxt (elapsed_next),
        .status      (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay   <= aos_pkg::START_DELAY_RST;
            cfg_reg.poll_interval <= aos_pkg::POLL_INTERVAL_RST;
            cfg_reg.window_low    <= aos_pkg::WINDOW_LOW_RST;
            cfg_reg.window_high   <= aos_pkg::WINDOW_HIGH_RST;
            cfg_reg.give_up       <= aos_pkg::GIVE_UP_RST;
            cfg_reg.reverse_wait  <= aos_pkg::REVERSE_WAIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                aos_pkg::REG_START_DELAY:   cfg_reg.start_delay   <= cfg.data;
                aos_pkg::REG_POLL_INTERVAL: cfg_reg.poll_interval <= cfg.data;
                aos_pkg::REG_WINDOW_LOW:    cfg_reg.window_low    <= cfg.data;
                aos_pkg::REG_WINDOW_HIGH:   cfg_reg.window_high   <= cfg.data;
                aos_pkg::REG_GIVE_UP:       cfg_reg.give_up       <= cfg.data;
                aos_pkg::REG_REVERSE_WAIT:  cfg_reg.reverse_wait  <= cfg.data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase       <= aos_pkg::PH_IDLE;
            ctrl_reg.wait_count  <= '0;
            ctrl_reg.open_level  <= 1'b0;
            ctrl_reg.close_level <= 1'b0;
            ctrl_reg.busy        <= 1'b0;
            ctrl_reg.finished    <= 1'b0;
            elapsed_reg          <= '0;
            res_valid_reg        <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            ctrl_reg      <= ctrl_next;
            elapsed_reg   <= elapsed_next;
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // status is payload: load on every command transfer
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            status_reg <= status_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.open_drive     = ctrl_reg.open_level;
    assign res.close_drive    = ctrl_reg.close_level;
    assign res.busy_res       = ctrl_reg.busy;
    assign res.port_open_flag = ctrl_reg.finished;
    assign res.status         = status_reg;
endmodule
`default_nettype wire

### src/aos_checker.sv
// Port-level checks for the actuator open sequencer, bound to the top level
`default_nettype none
`include "actuator_open_sequencer_defines.svh"
module aos_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       cmd_valid,
    input wire       cmd_ready,
    input wire       res_valid,
    input wire       res_ready,
    input wire       open_drive,
    input wire       close_drive,
    input wire       busy_res,
    input wire       port_open_flag,
    input wire [1:0] status
);
    logic [5:0] res_payload;
    logic       seq_ended;
    logic       open_or_timeout;

    assign res_payload     = {open_drive, close_drive, busy_res, port_open_flag, status};
    assign seq_ended       = res_valid && (status != aos_pkg::ST_NONE);
    assign open_or_timeout = res_valid &&
                             (status == aos_pkg::ST_OPENED || status == aos_pkg::ST_TIMEOUT);

    // a stalled result holds its value
    `AOS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_payload))

    // the command side stalls only behind a result that is not taken
    `AOS_ASSERT_IMPLY(a_cmd_ready, clk, rst_n, 1'b1, cmd_ready == (!res_valid || res_ready))

    // every command transfer offers a result on the next cycle
    `AOS_ASSERT_NEXT(a_res_after_cmd, clk, rst_n, cmd_valid && cmd_ready, res_valid)

    // an end of sequence leaves the block idle with the flag set
    `AOS_ASSERT_IMPLY(a_end_flags, clk, rst_n, seq_ended, !busy_res && port_open_flag)

    // success and timeout are only reached with the open drive asserted
    `AOS_ASSERT_IMPLY(a_end_drive, clk, rst_n, open_or_timeout, open_drive && !close_drive)
endmodule

bind actuator_open_sequencer aos_checker u_aos_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .open_drive     (res.open_drive),
    .close_drive    (res.close_drive),
    .busy_res       (res.busy_res),
    .port_open_flag (res.port_open_flag),
    .status         (res.status)
);
`default_nettype wire
